FILE: hdl/arrs_pkg.sv
// Package for the aging response ratio scheduler: widths, status codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package arrs_pkg;
  localparam int MAX_JOBS_DEF  = 16;
  localparam int TIME_BITS_DEF = 16;
  localparam int FIELD_W       = 16;
  localparam int SLOT_W        = 4;
  localparam int SCORE_W       = 32;
  localparam logic [15:0] AGING_RESET = 16'd3277;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_IDLE  = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [15:0] burst_length;
    logic [15:0] arrival_tick;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic        job_finished;
    logic [15:0] time_now;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic [15:0] response;
    logic        all_finished;
  } out_item_t;

  // classified command from front to back
  typedef struct packed {
    logic        is_tick;
    logic [15:0] burst;
    logic [15:0] arrival;
  } cmd_t;
endpackage

FILE: hdl/arrs_if.sv
// Valid/ready channel interfaces for the scheduler.
// Depends on arrs_pkg.
`timescale 1ns / 1ps
interface arrs_in_if;
  import arrs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arrs_out_if;
  import arrs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/arrs_front.sv
// Front end: accepts items, masks fields to the time width, two-entry queue.
// Depends on arrs_pkg.
`timescale 1ns / 1ps
module arrs_front #(
  parameter int TIME_BITS = arrs_pkg::TIME_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  arrs_pkg::in_item_t in_data,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output arrs_pkg::cmd_t  cmd
);
  import arrs_pkg::*;
  localparam logic [15:0] TMASK = (TIME_BITS >= 16) ? 16'hFFFF : 16'((1 << TIME_BITS) - 1);

  cmd_t q [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push, pop;
  cmd_t c;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q[rd_ptr];

  always_comb begin
    c.is_tick = (in_data.operation == OP_TICK);
    c.burst   = in_data.burst_length & TMASK;
    c.arrival = in_data.arrival_tick & TMASK;
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= c;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  a_nopush_full: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("push into full queue");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !pop) else $error("pop from empty queue");
endmodule

FILE: hdl/arrs_back.sv
// Back end: job table, sequential score scan with a serial divider, result register.
// Depends on arrs_pkg.
`timescale 1ns / 1ps
module arrs_back #(
  parameter int MAX_JOBS  = arrs_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = arrs_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [15:0]      aging_weight,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  arrs_pkg::cmd_t   cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output arrs_pkg::out_item_t out_data
);
  import arrs_pkg::*;
  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int TW = TIME_BITS;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};
  localparam int DW = 16 + TW;   // dividend width
  localparam int DSTEPS = DW + 1;  // divider steps: an init step plus one step per quotient bit
  localparam int DCW = $clog2(DW + 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_EXE  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [TW-1:0] mem_burst  [MAX_JOBS];
  logic [TW-1:0] mem_arr    [MAX_JOBS];
  logic [TW-1:0] mem_rem    [MAX_JOBS];
  logic [TW-1:0] mem_first  [MAX_JOBS];
  logic [MAX_JOBS-1:0] started;

  logic [2:0]    state;
  logic [CW-1:0] loaded, finished;
  logic [TW-1:0] tick;
  logic [CW-1:0] idx;
  logic [TW-1:0] r_burst, r_arr, r_rem, r_first;
  logic          found;
  logic [IW-1:0] best;
  logic [SCORE_W-1:0] best_score;
  logic [DW-1:0] quo;
  logic [TW:0]   rem;
  logic [DCW-1:0] dcnt;
  logic [TW-1:0] wait_t;
  logic [15+TW:0] aged_prod;
  logic [SCORE_W+TW:0] aged;
  logic [TW-1:0] new_burst, new_arr;
  out_item_t res;

  assign cmd_ready = (state == S_IDLE) && !out_valid;
  assign out_data = res;
  assign new_burst = TW'(cmd.burst);
  assign new_arr = TW'(cmd.arrival);

  assign wait_t = tick - r_arr;
  assign aged_prod = {{TW{1'b0}}, aging_weight} * {16'd0, wait_t};

  // divider step
  logic [TW:0] rem_sh;
  logic [TW:0] rem_sub;
  always_comb begin
    rem_sh  = {rem[TW-1:0], quo[DW-1]};
    rem_sub = rem_sh - {1'b0, r_burst};
  end

  logic [SCORE_W+TW+1:0] score_w;
  logic [SCORE_W-1:0] score;
  always_comb begin
    score_w = (SCORE_W+TW+2)'(65536) + (SCORE_W+TW+2)'(quo) + (SCORE_W+TW+2)'(aged);
    score = (score_w > (SCORE_W+TW+2)'({SCORE_W{1'b1}})) ? {SCORE_W{1'b1}}
            : score_w[SCORE_W-1:0];
  end

  logic [TW-1:0] tick_next;
  assign tick_next = (tick != TMAX) ? tick + 1'b1 : tick;

  logic [TW-1:0] tat, burst_b;
  assign tat = tick_next - r_arr;
  assign burst_b = r_burst;

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      r_burst <= mem_burst[idx[IW-1:0]];
      r_arr   <= mem_arr[idx[IW-1:0]];
      r_rem   <= mem_rem[idx[IW-1:0]];
      r_first <= mem_first[idx[IW-1:0]];
    end else if (state == S_CMP && idx == loaded && found) begin
      r_burst <= mem_burst[best];
      r_arr   <= mem_arr[best];
      r_rem   <= mem_rem[best];
      r_first <= mem_first[best];
    end
    if (state == S_IDLE && cmd_valid && cmd_ready && !cmd.is_tick
        && loaded != CW'(MAX_JOBS) && new_burst != '0) begin
      mem_burst[loaded[IW-1:0]] <= new_burst;
      mem_arr[loaded[IW-1:0]]   <= new_arr;
      mem_rem[loaded[IW-1:0]]   <= new_burst;
      mem_first[loaded[IW-1:0]] <= '0;
    end
    if (state == S_EXE) begin
      mem_rem[best] <= r_rem - 1'b1;
      if (!started[best]) mem_first[best] <= tick;
    end
    if (state == S_DIV) begin
      if (dcnt == '0) begin
        quo    <= {wait_t, 16'd0};
        rem    <= '0;
        aged   <= (SCORE_W+TW+1)'(aged_prod);
      end else begin
        if (!rem_sub[TW]) begin
          rem <= rem_sub;
          quo <= {quo[DW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[DW-2:0], 1'b0};
        end
      end
    end
    if (rst) begin
      state    <= S_IDLE;
      loaded   <= '0;
      finished <= '0;
      tick     <= '0;
      started  <= '0;
      out_valid <= 1'b0;
      idx <= '0;
      found <= 1'b0;
      best <= '0;
      best_score <= '0;
      dcnt <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            if (cmd.is_tick) begin
              res <= '0;
              idx <= '0;
              found <= 1'b0;
              best <= '0;
              best_score <= '0;
              state <= S_CMP;
            end else begin
              if (loaded == CW'(MAX_JOBS)) begin
                res <= '{status: ST_FULL, default: '0};
              end else if (new_burst == '0) begin
                res <= '{status: ST_BAD, default: '0};
              end else begin
                res <= '{status: ST_OK, slot: 4'(loaded), default: '0};
                started[loaded[IW-1:0]] <= 1'b0;
                loaded <= loaded + 1'b1;
              end
              state <= S_OUT;
            end
          end
        end
        S_RD: begin
          dcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (r_arr > tick || r_rem == '0) begin
            idx <= idx + 1'b1;
            state <= S_CMP;
          end else if (dcnt == DCW'(DSTEPS)) begin
            state <= S_CMP;
            dcnt <= '0;
          end else begin
            dcnt <= dcnt + 1'b1;
          end
        end
        S_CMP: begin
          // entered with idx pointing at the next slot to scan (0 at scan start), or at loaded once all are scanned
          if (dcnt == DCW'(DSTEPS)) begin
            dcnt <= '0;
          end
          if (idx == loaded) begin
            if (found) begin
              state <= S_EXE;
            end else begin
              res.status <= ST_IDLE;
              tick <= tick_next;
              state <= S_OUT;
            end
          end else begin
            state <= S_RD;
          end
        end
        S_EXE: begin
          if (!started[best]) started[best] <= 1'b1;
          tick <= tick_next;
          res.status <= ST_OK;
          res.slot <= 4'(best);
          if (r_rem == TW'(1)) begin
            res.job_finished <= 1'b1;
            finished <= finished + 1'b1;
            res.turnaround <= 16'(tat);
            res.waiting <= (tat >= burst_b) ? 16'(tat - burst_b) : 16'd0;
            res.response <= 16'((started[best] ? r_first : tick) - r_arr);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          res.time_now <= 16'(tick);
          res.all_finished <= (finished == loaded);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // score ready at end of division: compare and step
      if (state == S_DIV && !(r_arr > tick || r_rem == '0) && dcnt == DCW'(DSTEPS)) begin
        if (!found || score > best_score) begin
          found <= 1'b1;
          best <= idx[IW-1:0];
          best_score <= score;
        end
        idx <= idx + 1'b1;
      end
    end
  end

  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_IDLE) else $error("result while busy");
  a_fin: assert property (@(posedge clk) disable iff (rst)
    finished <= loaded) else $error("finished exceeds loaded");
  a_tick: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && tick != $past(tick) |-> tick == $past(tick) + 1'b1)
    else $error("tick jumped");
endmodule

FILE: hdl/aging_response_ratio_scheduler.sv
// Top level of the aging response ratio scheduler: config register, front and back.
// Depends on arrs_pkg, arrs_if, arrs_front, arrs_back.
//
//  channel    | dir | payload
//  in_ch      | in  | operation, burst_length, arrival_tick
//  out_ch     | out | status, slot, job_finished, time_now, turnaround, waiting,
//             |     | response, all_finished
//  cfg        | in  | cfg_we, cfg_wdata (aging_weight)
//
// A tick scores one loaded slot at a time with the bit-serial divider; a slot that has
// not arrived or is finished is skipped without a division.
// Synchronous reset clears the table counts and tick and sets aging_weight to 3277.
// The front queue holds two transfers while the back works or the output stalls.
`timescale 1ns / 1ps
module aging_response_ratio_scheduler #(
  parameter int MAX_JOBS  = arrs_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = arrs_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  arrs_in_if.sink     in_ch,
  arrs_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import arrs_pkg::*;
  logic [15:0] aging_weight;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) aging_weight <= AGING_RESET;
    else if (cfg_we) aging_weight <= cfg_wdata;
  end

  arrs_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .cmd_valid, .cmd_ready, .cmd
  );

  arrs_back #(.MAX_JOBS(MAX_JOBS), .TIME_BITS(TIME_BITS)) u_back (
    .clk, .rst, .aging_weight,
    .cmd_valid, .cmd_ready, .cmd,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule
